// ===== sv/assert_macros.svh =====
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== sv/tcsia_pkg.sv =====
// ----------------------------------------------------------------------------
// tcsia_pkg
// types and constants of the ternary chi-square interval accumulator
// ----------------------------------------------------------------------------
package tcsia_pkg;
    localparam logic [63:0] SAFE_BOUND = 64'd7530851732716320752;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_ZERO    = 3'd1,
        ST_BOUND   = 3'd2,
        ST_OVFL    = 3'd3,
        ST_HALTED  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_DEV, S_MUL, S_ACC, S_DIV, S_FLOOR, S_CEIL, S_DONE
    } state_t;

    typedef struct packed {
        logic start;
    } div_ctl_t;
endpackage

// ===== sv/tcsia_div.sv =====
// ----------------------------------------------------------------------------
// tcsia_div
// radix-2 restoring divider, 128 by 64 bits, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tcsia_div
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcsia_pkg::div_ctl_t  ctl,
    input  logic [127:0]         num,
    input  logic [63:0]          den,
    output logic                 done,
    output logic [127:0]         quo,
    output logic                 has_rem
);
    logic [127:0] q_reg;
    logic [64:0]  r_reg;
    logic [6:0]   cnt_reg;
    logic         run_reg;
    logic         done_reg;
    logic [64:0]  shifted;
    logic [64:0]  diff;

    assign shifted = {r_reg[63:0], q_reg[127]};
    assign diff    = shifted - {1'b0, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd127)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            q_reg <= num;
            r_reg <= '0;
        end
        else if (run_reg)
        begin
            if (!diff[64])
            begin
                r_reg <= diff;
                q_reg <= {q_reg[126:0], 1'b1};
            end
            else
            begin
                r_reg <= shifted;
                q_reg <= {q_reg[126:0], 1'b0};
            end
        end
    end

    assign done    = done_reg;
    assign quo     = q_reg;
    assign has_rem = (r_reg != '0);
endmodule

// ===== sv/ternary_chi_square_interval_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// ternary_chi_square_interval_accumulator_top
// chi-square bracket accumulator over three child counts per word
// ----------------------------------------------------------------------------
// an ok word passes through three squarings of four 32x32 partial products on one multiply
// and then the radix-2 divider; zero, bound, mass overflow and halted words skip both,
// numerator overflow skips the divider; one word in flight at a time
// next word accepted the cycle after the result word has been taken
// reset: asynchronous, active low, clears all accumulators and the halt flag
module ternary_chi_square_interval_accumulator_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        first_of_level,
    input  logic [63:0] count_zero,
    input  logic [63:0] count_one,
    input  logic [63:0] count_two,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] parent_mass,
    output logic [2:0]  status,
    output logic [63:0] lower_high,
    output logic [63:0] lower_low,
    output logic [63:0] upper_high,
    output logic [63:0] upper_low,
    output logic [63:0] remainder_count,
    output logic [63:0] mass_high,
    output logic [63:0] mass_low
);
    tcsia_pkg::state_t state_reg, state_next;
    logic [127:0] floor_reg, ceil_reg, mass_reg;
    logic [63:0]  tally_reg;
    logic         halted_reg;
    logic [63:0]  x_reg [3];
    logic [65:0]  p_reg;
    logic [1:0]   idx_reg;
    logic [63:0]  d_reg;
    logic [1:0]   mcnt_reg;
    logic [127:0] sq_reg;
    logic [128:0] num_reg;
    logic [128:0] fl_reg;
    logic [63:0]  pm_reg;
    logic [2:0]   st_reg;
    logic         outv_reg;
    logic         numov_reg;
    logic [128:0] mass_sum;
    logic [63:0]  a2, bm, dev;
    logic [31:0]  mul_a, mul_b;
    logic [63:0]  mul_prod;
    logic [127:0] mul_part;
    logic [128:0] num_add;
    logic [128:0] ceil_add;
    tcsia_pkg::div_ctl_t dctl;
    logic         ddone, dhas_rem;
    logic [127:0] dquo;

    tcsia_div u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (dctl),
        .num     (num_reg[127:0]),
        .den     (p_reg[63:0]),
        .done    (ddone),
        .quo     (dquo),
        .has_rem (dhas_rem)
    );

    assign mass_sum = {1'b0, mass_reg} + {63'd0, p_reg};
    assign a2       = {x_reg[idx_reg][62:0], 1'b0};
    assign bm       = p_reg[63:0] - x_reg[idx_reg];
    assign dev      = (a2 >= bm) ? a2 - bm : bm - a2;
    assign mul_a    = mcnt_reg[1] ? d_reg[63:32] : d_reg[31:0];
    assign mul_b    = mcnt_reg[0] ? d_reg[63:32] : d_reg[31:0];
    assign mul_prod = {32'd0, mul_a} * {32'd0, mul_b};
    assign num_add  = num_reg + {1'b0, sq_reg};
    assign ceil_add = {1'b0, ceil_reg} + {1'b0, dquo} + {128'd0, dhas_rem};

    always_comb
    begin
        unique case (mcnt_reg)
            2'd0:       mul_part = {64'd0, mul_prod};
            2'd1, 2'd2: mul_part = {32'd0, mul_prod, 32'd0};
            2'd3:       mul_part = {mul_prod, 64'd0};
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcsia_pkg::S_IDLE:  if (in_valid && in_ready) state_next = tcsia_pkg::S_CHECK;
            tcsia_pkg::S_CHECK:
            begin
                if (halted_reg || mass_sum[128] || p_reg == '0
                    || p_reg > {2'b0, tcsia_pkg::SAFE_BOUND})
                    state_next = tcsia_pkg::S_DONE;
                else
                    state_next = tcsia_pkg::S_DEV;
            end
            tcsia_pkg::S_DEV:   state_next = tcsia_pkg::S_MUL;
            tcsia_pkg::S_MUL:   state_next = (mcnt_reg == 2'd3) ? tcsia_pkg::S_ACC
                                                               : tcsia_pkg::S_MUL;
            tcsia_pkg::S_ACC:   state_next = (idx_reg == 2'd2) ? tcsia_pkg::S_DIV
                                                              : tcsia_pkg::S_DEV;
            tcsia_pkg::S_DIV:   state_next = (numov_reg || num_reg[128]) ? tcsia_pkg::S_DONE
                                                                          : tcsia_pkg::S_FLOOR;
            tcsia_pkg::S_FLOOR: if (ddone) state_next = tcsia_pkg::S_CEIL;
            tcsia_pkg::S_CEIL:  state_next = tcsia_pkg::S_DONE;
            tcsia_pkg::S_DONE:  if (!outv_reg) state_next = tcsia_pkg::S_IDLE;
            default:            state_next = tcsia_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = (state_reg == tcsia_pkg::S_IDLE) && !outv_reg;
        dctl.start = (state_reg == tcsia_pkg::S_DIV) && !numov_reg && !num_reg[128];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tcsia_pkg::S_IDLE;
            floor_reg  <= '0;
            ceil_reg   <= '0;
            mass_reg   <= '0;
            tally_reg  <= '0;
            halted_reg <= 1'b0;
            outv_reg   <= 1'b0;
            st_reg     <= '0;
            pm_reg     <= '0;
            numov_reg  <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (outv_reg && out_ready)
                outv_reg <= 1'b0;
            unique case (state_reg)
                tcsia_pkg::S_IDLE:
                begin
                    if (in_valid && in_ready && first_of_level)
                    begin
                        floor_reg  <= '0;
                        ceil_reg   <= '0;
                        mass_reg   <= '0;
                        tally_reg  <= '0;
                        halted_reg <= 1'b0;
                    end
                    idx_reg   <= '0;
                    numov_reg <= 1'b0;
                end
                tcsia_pkg::S_CHECK:
                begin
                    pm_reg <= '0;
                    if (halted_reg)
                        st_reg <= tcsia_pkg::ST_HALTED;
                    else if (mass_sum[128])
                        st_reg <= tcsia_pkg::ST_OVFL;
                    else if (p_reg == '0)
                        st_reg <= tcsia_pkg::ST_ZERO;
                    else if (p_reg > {2'b0, tcsia_pkg::SAFE_BOUND})
                        st_reg <= tcsia_pkg::ST_BOUND;
                    else
                        st_reg <= tcsia_pkg::ST_OK;
                    if (!halted_reg && (mass_sum[128] || p_reg == '0
                        || p_reg > {2'b0, tcsia_pkg::SAFE_BOUND}))
                        halted_reg <= 1'b1;
                end
                tcsia_pkg::S_ACC:
                begin
                    if (num_add[128])
                        numov_reg <= 1'b1;
                    idx_reg <= idx_reg + 2'd1;
                end
                tcsia_pkg::S_DIV:
                begin
                    if (numov_reg || num_reg[128])
                    begin
                        st_reg     <= tcsia_pkg::ST_OVFL;
                        halted_reg <= 1'b1;
                    end
                end
                tcsia_pkg::S_CEIL:
                begin
                    if (fl_reg[128] || ceil_add[128])
                    begin
                        st_reg     <= tcsia_pkg::ST_OVFL;
                        halted_reg <= 1'b1;
                    end
                    else
                    begin
                        floor_reg <= fl_reg[127:0];
                        ceil_reg  <= ceil_add[127:0];
                        mass_reg  <= mass_sum[127:0];
                        tally_reg <= tally_reg + {63'd0, dhas_rem};
                        pm_reg    <= p_reg[63:0];
                    end
                end
                tcsia_pkg::S_DONE:
                begin
                    if (!outv_reg)
                        outv_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x_reg[0] <= count_zero;
            x_reg[1] <= count_one;
            x_reg[2] <= count_two;
            p_reg    <= {2'b0, count_zero} + {2'b0, count_one} + {2'b0, count_two};
        end
        if (state_reg == tcsia_pkg::S_CHECK)
            num_reg <= '0;
        if (state_reg == tcsia_pkg::S_DEV)
        begin
            d_reg    <= dev;
            sq_reg   <= '0;
            mcnt_reg <= '0;
        end
        if (state_reg == tcsia_pkg::S_MUL)
        begin
            sq_reg   <= sq_reg + mul_part;
            mcnt_reg <= mcnt_reg + 2'd1;
        end
        if (state_reg == tcsia_pkg::S_ACC)
            num_reg <= {1'b0, num_add[127:0]};
        if (state_reg == tcsia_pkg::S_FLOOR && ddone)
            fl_reg <= {1'b0, floor_reg} + {1'b0, dquo};
    end

    assign out_valid       = outv_reg;
    assign parent_mass     = pm_reg;
    assign status          = st_reg;
    assign lower_high      = floor_reg[127:64];
    assign lower_low       = floor_reg[63:0];
    assign upper_high      = ceil_reg[127:64];
    assign upper_low       = ceil_reg[63:0];
    assign remainder_count = tally_reg;
    assign mass_high       = mass_reg[127:64];
    assign mass_low        = mass_reg[63:0];
endmodule

// ===== sv/tcsia_checker.sv =====
// ----------------------------------------------------------------------------
// tcsia_checker
// port-level checks of the accumulator handshake and status rules
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tcsia_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [63:0] parent_mass
);
    logic err_word;

    assign err_word = out_valid && (status != tcsia_pkg::ST_OK);

    `ASSERT_IMPL(a_no_accept_while_out, clk, rst_n, out_valid, !in_ready)
    `ASSERT_IMPL(a_pm_zero_on_err, clk, rst_n, err_word, parent_mass == '0)
    `ASSERT_IMPL(a_status_range, clk, rst_n, out_valid, status <= tcsia_pkg::ST_HALTED)
    `ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status))
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule

bind ternary_chi_square_interval_accumulator_top tcsia_checker u_chk
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .parent_mass (parent_mass)
);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// checks the ternary chi-square interval accumulator word by word against a
// behavioral model of the floor and ceiling sums, mass, tally and halt flag
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        first_of_level = 1'b0;
    logic [63:0] count_zero = '0;
    logic [63:0] count_one = '0;
    logic [63:0] count_two = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] parent_mass;
    logic [2:0]  status;
    logic [63:0] lower_high, lower_low, upper_high, upper_low;
    logic [63:0] remainder_count, mass_high, mass_low;

    typedef struct {
        logic [63:0]        pm;
        tcsia_pkg::status_t st;
        logic [127:0]       fl;
        logic [127:0]       ce;
        logic [63:0]        tally;
        logic [127:0]       mass;
    } acc_word_t;

    acc_word_t   expected_words[$];
    logic [127:0] floor_acc, ceil_acc, mass_acc;
    logic [63:0]  tally_acc;
    logic         halt_flag;
    int           mismatches = 0;
    int           words_sent = 0;
    int           words_checked = 0;
    int           ok_seen = 0;
    int           err_seen = 0;

    ternary_chi_square_interval_accumulator_top u_top (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [63:0] dev3(logic [63:0] x, logic [63:0] p);
        logic [64:0] a;
        logic [64:0] b;
        a = {x, 1'b0};
        b = {1'b0, p - x};
        return (a >= b) ? 64'(a - b) : 64'(b - a);
    endfunction

    function automatic acc_word_t chi_accumulate(logic fol, logic [63:0] x0,
                                                 logic [63:0] x1, logic [63:0] x2);
        acc_word_t          w;
        logic [65:0]        p;
        logic [128:0]       m, n, f, c;
        logic [63:0]        d;
        logic [127:0]       q;
        logic [127:0]       r;
        tcsia_pkg::status_t st;
        if (fol)
        begin
            floor_acc = '0; ceil_acc = '0; mass_acc = '0; tally_acc = '0; halt_flag = 1'b0;
        end
        st = tcsia_pkg::ST_OK;
        w.pm = '0;
        if (halt_flag)
            st = tcsia_pkg::ST_HALTED;
        else
        begin
            p = 66'(x0) + 66'(x1) + 66'(x2);
            m = 129'(mass_acc) + 129'(p);
            if (m[128])
                st = tcsia_pkg::ST_OVFL;
            else if (p == 0)
                st = tcsia_pkg::ST_ZERO;
            else if (p > 66'(tcsia_pkg::SAFE_BOUND))
                st = tcsia_pkg::ST_BOUND;
            else
            begin
                d = dev3(x0, p[63:0]);
                n = 129'(128'(d) * 128'(d));
                d = dev3(x1, p[63:0]);
                n = n + 129'(128'(d) * 128'(d));
                if (!n[128])
                begin
                    d = dev3(x2, p[63:0]);
                    n = n + 129'(128'(d) * 128'(d));
                end
                if (n[128])
                    st = tcsia_pkg::ST_OVFL;
                else
                begin
                    q = n[127:0] / 128'(p[63:0]);
                    r = n[127:0] % 128'(p[63:0]);
                    f = 129'(floor_acc) + 129'(q);
                    c = 129'(ceil_acc) + 129'(q);
                    if (!c[128])
                        c = c + 129'(r != 0);
                    if (f[128] || c[128])
                        st = tcsia_pkg::ST_OVFL;
                    else
                    begin
                        floor_acc = f[127:0];
                        ceil_acc = c[127:0];
                        mass_acc = m[127:0];
                        tally_acc = tally_acc + 64'(r != 0);
                        w.pm = p[63:0];
                    end
                end
            end
            if (st != tcsia_pkg::ST_OK)
                halt_flag = 1'b1;
        end
        w.st = st;
        w.fl = floor_acc;
        w.ce = ceil_acc;
        w.tally = tally_acc;
        w.mass = mass_acc;
        return w;
    endfunction

    task automatic send_word(logic fol, logic [63:0] x0, logic [63:0] x1, logic [63:0] x2);
        in_valid <= 1'b1;
        first_of_level <= fol;
        count_zero <= x0;
        count_one <= x1;
        count_two <= x2;
        expected_words.insert(expected_words.size(), chi_accumulate(fol, x0, x1, x2));
        do @(posedge clk); while (!in_ready);
        words_sent++;
        if ($urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic idle_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(0, 9) < 7) || (words_sent % 200 < 40);
    end

    always @(posedge clk)
    begin
        acc_word_t e;
        logic      bad;
        if (rst_n && out_valid && out_ready)
        begin
            words_checked++;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word status=%0d", status);
            end
            else
            begin
                e = expected_words.pop_front();
                if (e.st == tcsia_pkg::ST_OK) ok_seen++; else err_seen++;
                bad = parent_mass !== e.pm || status !== e.st
                    || {lower_high, lower_low} !== e.fl || {upper_high, upper_low} !== e.ce
                    || remainder_count !== e.tally || {mass_high, mass_low} !== e.mass;
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: exp pm=%h st=%0d fl=%h ce=%h rc=%h m=%h",
                            e.pm, e.st, e.fl, e.ce, e.tally, e.mass);
                        $display("          got pm=%h st=%0d fl=%h ce=%h rc=%h m=%h",
                            parent_mass, status, {lower_high, lower_low},
                            {upper_high, upper_low}, remainder_count,
                            {mass_high, mass_low});
                    end
                end
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_count();
        case ($urandom_range(0, 5))
            0: return 64'($urandom_range(0, 20));
            1: return 64'($urandom);
            2: return rand64() >> 2;
            3: return rand64() >> $urandom_range(2, 40);
            4: return rand64();
            default: return 64'($urandom_range(0, 1000));
        endcase
    endfunction

    task automatic test_directed();
        send_word(1'b1, 64'd1, 64'd2, 64'd3);
        send_word(1'b0, 64'd0, 64'd0, 64'd0);
        send_word(1'b0, 64'd5, 64'd5, 64'd5);
        send_word(1'b1, 64'd7, 64'd7, 64'd7);
        send_word(1'b0, 64'd1, 64'd0, 64'd0);
        send_word(1'b0, tcsia_pkg::SAFE_BOUND, 64'd0, 64'd0);
        send_word(1'b1, tcsia_pkg::SAFE_BOUND, 64'd0, 64'd0);
        send_word(1'b1, tcsia_pkg::SAFE_BOUND + 64'd1, 64'd0, 64'd0);
        send_word(1'b1, '1, '1, '1);
        send_word(1'b0, 64'd3, 64'd3, 64'd3);
        send_word(1'b1, 64'h5555_5555_5555_5555, 64'h1111_1111_1111_1111, 64'd0);
        send_word(1'b1, tcsia_pkg::SAFE_BOUND / 3, tcsia_pkg::SAFE_BOUND / 3,
                  tcsia_pkg::SAFE_BOUND / 3);
        send_word(1'b1, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'd0);
        send_word(1'b1, 64'd2, 64'd0, 64'd1);
        repeat (6) send_word(1'b0, 64'h2000_0000_0000_0000, 64'd0, 64'd0);
        send_word(1'b0, 64'd1, 64'd1, 64'd1);
        send_word(1'b1, 64'd0, 64'd0, 64'd1);
    endtask

    task automatic test_random_levels();
        int n;
        n = 0;
        while (n < 2000)
        begin
            send_word($urandom_range(0, 30) == 0, rand_count(), rand_count(), rand_count());
            n++;
            if ($urandom_range(0, 50) == 0)
                repeat ($urandom_range(1, 20)) idle_input();
        end
    endtask

    task automatic test_bit_toggle();
        for (int b = 0; b < 64; b++)
        begin
            send_word(1'b1, 64'd1 << b, ~(64'd1 << b) >> 3, 64'd0);
            send_word(1'b0, ~(64'd1 << b), 64'd1 << b, 64'd1 << b);
        end
    endtask

    initial
    begin
        floor_acc = '0; ceil_acc = '0; mass_acc = '0; tally_acc = '0; halt_flag = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_bit_toggle();
        test_random_levels();
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        $display("sent %0d words, checked %0d results (%0d ok, %0d error or halted)",
            words_sent, words_checked, ok_seen, err_seen);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb failed");
        $finish;
    end
endmodule

// ===== ternary_chi_square_interval_accumulator_top.f =====
+incdir+sv
sv/tcsia_pkg.sv
sv/tcsia_div.sv
sv/ternary_chi_square_interval_accumulator_top.sv
sv/tcsia_checker.sv
sim/tb.sv
